// ===== rtl/core/tsc_pkg.sv =====
package tsc_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int IDX_W      = 24;
  localparam int THR_W      = 32;
  localparam int THR_FRAC   = 30;
  localparam logic signed [THR_W-1:0] THR_RESET = 32'h4000_0000;

  // Datapath widths: edge components, products, dot and squared norms
  localparam int EDGE_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int MAG_W  = 2 * COORD_BITS + 2;
  localparam int SUM_W  = MAG_W + 1;

  // Wide products: |a|^2*|b|^2, threshold squared, final compare
  localparam int S_W    = 2 * MAG_W;
  localparam int TSQ_W  = 2 * THR_W;
  localparam int CMP_W  = S_W + TSQ_W;
  localparam int SQ_SH  = 2 * THR_FRAC;

  // Limb-split multiplier geometry
  localparam int WM_W   = (S_W > TSQ_W) ? S_W : TSQ_W;
  localparam int LIMB_W = 26;
  localparam int NL     = (WM_W + LIMB_W - 1) / LIMB_W;
  localparam int PAD_W  = NL * LIMB_W;
  localparam int PP_W   = 2 * LIMB_W;
  localparam int ROW_W  = (NL + 1) * LIMB_W;
  localparam int PW     = 2 * NL * LIMB_W;

  // Pipeline stage numbers
  localparam int N_STG   = 11;
  localparam int ST_EDGE = 1;
  localparam int ST_PROD = 2;
  localparam int ST_SUM  = 3;
  localparam int ST_ABS  = 4;
  localparam int ST_MAC  = 7;
  localparam int ST_CMP  = 10;
  localparam int ST_OUT  = 11;

  typedef logic signed [COORD_BITS-1:0] tsc_coord_t;
  typedef tsc_coord_t [2:0]             tsc_vtx_t;
  typedef logic signed [EDGE_W-1:0]     tsc_edge_t;
  typedef tsc_edge_t [2:0]              tsc_evec_t;
  typedef logic [N_STG:1]               tsc_stg_t;

  typedef struct packed {
    logic pp;
    logic row;
    logic fin;
  } tsc_mul_en_t;

  typedef struct packed {
    logic dneg;
    logic zero;
  } tsc_flag_t;

endpackage

// ===== rtl/core/tsc_wmul.sv =====
module tsc_wmul import tsc_pkg::*; (
  input  logic              clk,
  input  tsc_mul_en_t       en,
  input  logic [WM_W-1:0]   a,
  input  logic [WM_W-1:0]   b,
  output logic [PW-1:0]     p
);

  logic [PAD_W-1:0] a_pad;
  logic [PAD_W-1:0] b_pad;
  logic [PP_W-1:0]  a_limb;
  logic [PP_W-1:0]  b_limb;
  logic [PP_W-1:0]  pp_nxt  [NL][NL];
  logic [PP_W-1:0]  pp_r    [NL][NL];
  logic [ROW_W-1:0] row_acc;
  logic [ROW_W-1:0] row_nxt [NL];
  logic [ROW_W-1:0] row_r   [NL];
  logic [PW-1:0]    p_nxt;
  logic [PW-1:0]    p_r;

  // Form limb partial products
  always_comb begin
    a_pad = PAD_W'(a);
    b_pad = PAD_W'(b);
    a_limb = '0;
    b_limb = '0;
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        a_limb = PP_W'(a_pad[i*LIMB_W +: LIMB_W]);
        b_limb = PP_W'(b_pad[j*LIMB_W +: LIMB_W]);
        pp_nxt[i][j] = a_limb * b_limb;
      end
    end
  end

  // Collapse each row of partial products
  always_comb begin
    row_acc = '0;
    for (int i = 0; i < NL; i++) begin
      row_acc = '0;
      for (int j = 0; j < NL; j++) begin
        row_acc = row_acc + (ROW_W'(pp_r[i][j]) << (j * LIMB_W));
      end
      row_nxt[i] = row_acc;
    end
  end

  // Sum the rows into the full product
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < NL; i++) begin
      p_nxt = p_nxt + (PW'(row_r[i]) << (i * LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en.pp) begin
      pp_r <= pp_nxt;
    end
    if (en.row) begin
      row_r <= row_nxt;
    end
    if (en.fin) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/core/tsc_corner.sv =====
module tsc_corner import tsc_pkg::*; (
  input  logic                    clk,
  input  tsc_stg_t                en,
  input  tsc_evec_t               edge_a,
  input  tsc_evec_t               edge_b,
  input  logic signed [THR_W-1:0] thr,
  input  logic [TSQ_W-1:0]        tsq,
  output logic                    straight
);

  logic signed [PROD_W-1:0] dp_r  [3];
  logic signed [PROD_W-1:0] sqa_r [3];
  logic signed [PROD_W-1:0] sqb_r [3];
  logic signed [SUM_W-1:0]  dot_nxt;
  logic signed [SUM_W-1:0]  sa_sum;
  logic signed [SUM_W-1:0]  sb_sum;
  logic signed [SUM_W-1:0]  dot_r;
  logic signed [SUM_W-1:0]  dot_abs;
  logic [MAG_W-1:0]         sa_r;
  logic [MAG_W-1:0]         sb_r;
  logic [MAG_W-1:0]         dmag_r [ST_ABS:ST_MAC-1];
  tsc_flag_t                fl_nxt;
  tsc_flag_t                fl_r   [ST_ABS:ST_CMP-1];
  logic [PW-1:0]            s_prod;
  logic [PW-1:0]            d2_prod;
  logic [PW-1:0]            r_prod;
  logic [CMP_W-1:0]         lhs;
  logic [CMP_W-1:0]         rhs;
  logic                     thr_pos;
  logic                     straight_nxt;
  logic                     straight_r;

  // Component products for the dot product and both squared norms
  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      for (int k = 0; k < 3; k++) begin
        dp_r[k]  <= $signed(edge_a[k]) * $signed(edge_b[k]);
        sqa_r[k] <= $signed(edge_a[k]) * $signed(edge_a[k]);
        sqb_r[k] <= $signed(edge_b[k]) * $signed(edge_b[k]);
      end
    end
  end

  // Add the three components
  always_comb begin
    dot_nxt = dp_r[0] + dp_r[1] + dp_r[2];
    sa_sum  = sqa_r[0] + sqa_r[1] + sqa_r[2];
    sb_sum  = sqb_r[0] + sqb_r[1] + sqb_r[2];
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      dot_r <= dot_nxt;
      sa_r  <= sa_sum[MAG_W-1:0];
      sb_r  <= sb_sum[MAG_W-1:0];
    end
  end

  // Split the dot product into sign and magnitude; a zero norm means a zero edge
  always_comb begin
    dot_abs     = dot_r[SUM_W-1] ? -dot_r : dot_r;
    fl_nxt.dneg = dot_r[SUM_W-1];
    fl_nxt.zero = (sa_r == '0) || (sb_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      dmag_r[ST_ABS] <= dot_abs[MAG_W-1:0];
      fl_r[ST_ABS]   <= fl_nxt;
    end
    for (int k = ST_ABS + 1; k < ST_MAC; k++) begin
      if (en[k]) begin
        dmag_r[k] <= dmag_r[k-1];
      end
    end
    for (int k = ST_ABS + 1; k < ST_CMP; k++) begin
      if (en[k]) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // |a|^2 * |b|^2
  tsc_wmul u_mul_norm (
    .clk (clk),
    .en  (tsc_mul_en_t'{pp: en[ST_ABS], row: en[ST_ABS+1], fin: en[ST_ABS+2]}),
    .a   (WM_W'(sa_r)),
    .b   (WM_W'(sb_r)),
    .p   (s_prod)
  );

  // dot^2
  tsc_wmul u_mul_dot (
    .clk (clk),
    .en  (tsc_mul_en_t'{pp: en[ST_MAC], row: en[ST_MAC+1], fin: en[ST_MAC+2]}),
    .a   (WM_W'(dmag_r[ST_MAC-1])),
    .b   (WM_W'(dmag_r[ST_MAC-1])),
    .p   (d2_prod)
  );

  // t^2 * |a|^2 * |b|^2
  tsc_wmul u_mul_thr (
    .clk (clk),
    .en  (tsc_mul_en_t'{pp: en[ST_MAC], row: en[ST_MAC+1], fin: en[ST_MAC+2]}),
    .a   (WM_W'(tsq)),
    .b   (WM_W'(s_prod[S_W-1:0])),
    .p   (r_prod)
  );

  // Decide by a zero edge and the signs first, then by the squared comparison
  always_comb begin
    thr_pos = !thr[THR_W-1] && (thr != '0);
    lhs     = CMP_W'({d2_prod[S_W-1:0], {SQ_SH{1'b0}}});
    rhs     = r_prod[CMP_W-1:0];
    priority if (fl_r[ST_CMP-1].zero) begin
      straight_nxt = !thr_pos;
    end else if (!fl_r[ST_CMP-1].dneg && !thr_pos) begin
      straight_nxt = 1'b1;
    end else if (fl_r[ST_CMP-1].dneg && thr_pos) begin
      straight_nxt = 1'b0;
    end else if (fl_r[ST_CMP-1].dneg) begin
      straight_nxt = (lhs <= rhs);
    end else begin
      straight_nxt = (lhs >= rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CMP]) begin
      straight_r <= straight_nxt;
    end
  end

  assign straight = straight_r;

endmodule

// ===== rtl/core/triangle_straight_corner_check.sv =====
// A result passes through 11 register stages after its input beat is accepted.
// Throughput: one triangle per cycle; a stall holds only the occupied stages with no empty stage
// after them, so bubbles are squeezed out and the input keeps taking beats while the pipeline has an empty stage.
// The depth is set by the two chained wide multiplies (three stages each) per corner.
// Reset: rst_n (synchronous, active low) clears all stage valid bits and loads the cosine
// threshold with 1.0; there is no clearing pass.
module triangle_straight_corner_check import tsc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [IDX_W-1:0]             in_tri_index,
  input  logic signed [COORD_BITS-1:0] in_v0_x,
  input  logic signed [COORD_BITS-1:0] in_v0_y,
  input  logic signed [COORD_BITS-1:0] in_v0_z,
  input  logic signed [COORD_BITS-1:0] in_v1_x,
  input  logic signed [COORD_BITS-1:0] in_v1_y,
  input  logic signed [COORD_BITS-1:0] in_v1_z,
  input  logic signed [COORD_BITS-1:0] in_v2_x,
  input  logic signed [COORD_BITS-1:0] in_v2_y,
  input  logic signed [COORD_BITS-1:0] in_v2_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [IDX_W-1:0]             out_index,
  output logic                         out_is_bad,
  input  logic                         cfg_we,
  input  logic signed [THR_W-1:0]      cfg_wdata
);

  logic signed [THR_W-1:0] thr_r;
  logic signed [THR_W-1:0] thr_abs;
  logic [THR_W-1:0]        thr_abs_u;
  logic [TSQ_W-1:0]        thr_mag_w;
  logic [TSQ_W-1:0]        tsq_nxt;
  logic [TSQ_W-1:0]        tsq_r;
  tsc_stg_t                v_r;
  tsc_stg_t                v_prev;
  tsc_stg_t                v_nxt;
  tsc_stg_t                en;
  logic                    full;
  tsc_vtx_t                vtx [3];
  tsc_evec_t               edge_nxt [3];
  tsc_evec_t               edge_r   [3];
  logic [IDX_W-1:0]        idx_r [ST_EDGE:ST_CMP];
  logic [2:0]              straight;
  logic [IDX_W-1:0]        out_index_r;
  logic                    is_bad_r;
  logic                    in_fire;
  logic                    out_fire;

  function automatic tsc_evec_t edge_of(input tsc_vtx_t head, input tsc_vtx_t tail);
    tsc_evec_t e;
    for (int k = 0; k < 3; k++) begin
      e[k] = $signed({head[k][COORD_BITS-1], head[k]})
           - $signed({tail[k][COORD_BITS-1], tail[k]});
    end
    return e;
  endfunction

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // Square the threshold magnitude; the registered square follows each configuration write
  always_comb begin
    thr_abs   = thr_r[THR_W-1] ? -thr_r : thr_r;
    thr_abs_u = thr_abs;
    thr_mag_w = TSQ_W'(thr_abs_u);
    tsq_nxt   = thr_mag_w * thr_mag_w;
  end

  always_ff @(posedge clk) begin
    tsq_r <= tsq_nxt;
  end

  // Stage enables: a stage loads when the output is ready or some stage at or after it is empty
  always_comb begin
    full = 1'b1;
    for (int k = 1; k <= N_STG; k++) begin
      full = 1'b1;
      for (int j = k; j <= N_STG; j++) begin
        full = full & v_r[j];
      end
      en[k] = out_ready || !full;
    end
    v_prev = {v_r[N_STG-1:1], in_valid};
    v_nxt  = (en & v_prev) | (~en & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Edges: e0 = v1 - v0, e1 = v2 - v1, e2 = v0 - v2
  always_comb begin
    vtx[0] = {in_v0_z, in_v0_y, in_v0_x};
    vtx[1] = {in_v1_z, in_v1_y, in_v1_x};
    vtx[2] = {in_v2_z, in_v2_y, in_v2_x};
    edge_nxt[0] = edge_of(vtx[1], vtx[0]);
    edge_nxt[1] = edge_of(vtx[2], vtx[1]);
    edge_nxt[2] = edge_of(vtx[0], vtx[2]);
  end

  // Capture edges and carry the index along
  always_ff @(posedge clk) begin
    if (en[ST_EDGE]) begin
      edge_r          <= edge_nxt;
      idx_r[ST_EDGE]  <= in_tri_index;
    end
    for (int k = ST_EDGE + 1; k <= ST_CMP; k++) begin
      if (en[k]) begin
        idx_r[k] <= idx_r[k-1];
      end
    end
  end

  // Corner at v0: in e2, out e0
  tsc_corner u_corner0 (
    .clk      (clk),
    .en       (en),
    .edge_a   (edge_r[2]),
    .edge_b   (edge_r[0]),
    .thr      (thr_r),
    .tsq      (tsq_r),
    .straight (straight[0])
  );

  // Corner at v1: in e0, out e1
  tsc_corner u_corner1 (
    .clk      (clk),
    .en       (en),
    .edge_a   (edge_r[0]),
    .edge_b   (edge_r[1]),
    .thr      (thr_r),
    .tsq      (tsq_r),
    .straight (straight[1])
  );

  // Corner at v2: in e1, out e2
  tsc_corner u_corner2 (
    .clk      (clk),
    .en       (en),
    .edge_a   (edge_r[1]),
    .edge_b   (edge_r[2]),
    .thr      (thr_r),
    .tsq      (tsq_r),
    .straight (straight[2])
  );

  // Output register: flag the triangle if any corner is straight
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_index_r <= idx_r[ST_CMP];
      is_bad_r    <= |straight;
    end
  end

  assign in_ready   = en[ST_EDGE];
  assign out_valid  = v_r[ST_OUT];
  assign out_index  = out_index_r;
  assign out_is_bad = is_bad_r;
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;

  // An empty output stage must leave the whole pipe open to input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  // Reset empties every stage
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("stage valid bits not cleared by reset");

  // Occupancy changes only by accepted input and output beats
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $past($countones(v_r))
                      + int'($past(in_fire)) - int'($past(out_fire))))
    else $error("beat lost or duplicated inside the pipeline");

endmodule
